### hw/rtl/llsched_pkg.sv
// ----------------------------------------------------------------------------
// llsched_pkg
// Shared types and constants of the least-laxity job scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package llsched_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  job_id;
    logic [15:0] release_time;
    logic [15:0] exec_time;
    logic [15:0] abs_deadline;
  } item_t;

  typedef struct packed {
    logic [15:0] now;
    logic        ran_valid;
    logic [7:0]  ran_id;
    logic        done_res;
    logic [15:0] done_wait;
    logic [15:0] done_cpu;
    logic        status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_UPDATE,
    ST_REPORT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the item
    logic add;       // store the job in the lowest free slot
    logic scan_clr;  // reset the scan index and best pick
    logic scan_step; // examine one slot
    logic upd_step;  // update one slot
    logic finish;    // advance time after a tick, build the result
    logic emit;      // drive the result strobe
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic upd_last;
  } stat_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/llsched_ctrl.sv
// ----------------------------------------------------------------------------
// llsched_ctrl
// Sequencer: add in one step, tick as a slot scan followed by a slot update.
// ----------------------------------------------------------------------------
`default_nettype none
module llsched_ctrl
  import llsched_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (stat.is_tick) begin
          cmd.scan_clr = 1'b1;
          state_next   = ST_SCAN;
        end else begin
          cmd.add    = 1'b1;
          state_next = ST_REPORT;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.upd_step = 1'b1;
        if (stat.upd_last) begin
          cmd.finish = 1'b1;
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_emit_only_report: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == ST_IDLE) else $error("emit left report state wrong");
  a_scan_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan_step && cmd.upd_step)) else $error("scan and update overlap");

endmodule
`default_nettype wire

### hw/rtl/llsched_dp.sv
// ----------------------------------------------------------------------------
// llsched_dp
// Job table and the serial least-laxity scan and update.
// ----------------------------------------------------------------------------
`default_nettype none
module llsched_dp
  import llsched_pkg::*;
#(
  parameter int MAX_JOBS = 16
)(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  item_t   item,
  output stat_t   stat,
  output result_t result
);

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam logic [IW-1:0] LAST = IW'(MAX_JOBS - 1);

  logic [MAX_JOBS-1:0] valid;
  logic [7:0]  s_id      [MAX_JOBS];
  logic [15:0] s_rel     [MAX_JOBS];
  logic [15:0] s_rem     [MAX_JOBS];
  logic [15:0] s_dl      [MAX_JOBS];
  logic [15:0] s_wait    [MAX_JOBS];
  logic [15:0] s_cpu     [MAX_JOBS];
  logic [15:0] s_ord     [MAX_JOBS];

  item_t       cur;
  logic [15:0] cur_time;
  logic [15:0] ins_cnt;
  logic [IW-1:0] idx;
  logic        best_ok;
  logic [IW-1:0] best;
  logic signed [16:0] best_lax;
  logic [15:0] best_ord;
  result_t     res;

  // free slot search and current slot view
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic          rdy;
  logic signed [16:0] lax;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign rdy = valid[idx] && (s_rel[idx] <= cur_time);
  assign lax = $signed({1'b0, s_dl[idx]}) - $signed({1'b0, s_rem[idx]});

  assign stat.is_tick   = (cur.operation == OP_TICK);
  assign stat.scan_last = (idx == LAST);
  assign stat.upd_last  = (idx == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      cur_time <= '0;
      ins_cnt  <= '0;
      idx      <= '0;
      best_ok  <= 1'b0;
    end else begin
      if (cmd.load) begin
        cur <= item;
        res <= '0;
      end
      if (cmd.add) begin
        res.now <= cur_time;
        if (!free_ok) begin
          res.status <= 1'b1;
        end else begin
          valid[free_idx]  <= 1'b1;
          s_id[free_idx]   <= cur.job_id;
          s_rel[free_idx]  <= cur.release_time;
          s_rem[free_idx]  <= cur.exec_time;
          s_dl[free_idx]   <= cur.abs_deadline;
          s_wait[free_idx] <= '0;
          s_cpu[free_idx]  <= '0;
          s_ord[free_idx]  <= ins_cnt;
          ins_cnt          <= ins_cnt + 16'd1;
        end
      end
      if (cmd.scan_clr) begin
        idx     <= '0;
        best_ok <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (rdy && (!best_ok || lax < best_lax ||
                    (lax == best_lax && s_ord[idx] < best_ord))) begin
          best_ok  <= 1'b1;
          best     <= idx;
          best_lax <= lax;
          best_ord <= s_ord[idx];
        end
        idx <= stat.scan_last ? '0 : idx + 1'b1;
      end
      if (cmd.upd_step && best_ok) begin
        if (idx == best) begin
          res.ran_valid <= 1'b1;
          res.ran_id    <= s_id[idx];
          s_cpu[idx]    <= sat_inc(s_cpu[idx]);
          if (s_rem[idx] <= 16'd1) begin
            s_rem[idx]    <= '0;
            valid[idx]    <= 1'b0;
            res.done_res  <= 1'b1;
            res.done_wait <= s_wait[idx];
            res.done_cpu  <= sat_inc(s_cpu[idx]);
          end else begin
            s_rem[idx] <= s_rem[idx] - 16'd1;
          end
        end else if (rdy) begin
          s_wait[idx] <= sat_inc(s_wait[idx]);
        end
      end
      if (cmd.upd_step) begin
        idx <= stat.upd_last ? '0 : idx + 1'b1;
      end
      if (cmd.finish) begin
        cur_time <= cur_time + 16'd1;
        res.now  <= cur_time + 16'd1;
      end
    end
  end

  assign result = res;

  a_done_ran: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && res.done_res |-> res.ran_valid) else $error("done without run");
  a_add_no_run: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !stat.is_tick |-> !res.ran_valid) else $error("add reported a run");

endmodule
`default_nettype wire

### hw/rtl/least_laxity_job_scheduler.sv
// ----------------------------------------------------------------------------
// least_laxity_job_scheduler
// Preemptive least-laxity-first scheduler over a fixed job table.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------
//  command  | start / busy       | item   (item_t)
//  result   | done strobe        | result (result_t)
//
// The result strobe comes in the REPORT state, after the ADD state for an add,
// and after the ADD, SCAN and UPDATE states for a tick: the laxity scan takes
// one slot per cycle, then the wait/cpu update takes one slot per cycle, both
// walking the table through one index. Busy drops in the cycle after the
// strobe, as the REPORT state returns to IDLE.
// Reset (rst, synchronous) empties the table and zeroes time and insert order.
// The result is shown for one cycle; the receiver cannot stall it.
`default_nettype none
module least_laxity_job_scheduler
  import llsched_pkg::*;
#(
  parameter int MAX_JOBS = 16
)(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  cmd_t  cmd;
  stat_t stat;

  // sequence the job: one step for add, scan then update for a tick
  llsched_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  // hold the table, time and the running best pick
  llsched_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .item  (item),
    .stat  (stat),
    .result(result)
  );

  assign done = cmd.emit;

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe while idle");

endmodule
`default_nettype wire

### tb/least_laxity_job_scheduler_tb.sv
// ----------------------------------------------------------------------------
// least_laxity_job_scheduler_tb
// Self-checking bench for the least-laxity job scheduler. A queue of job adds
// and ticks feeds a start/busy driver. Each transfer runs through a local
// least-laxity predictor, and a monitor compares every result strobe with the
// oldest predicted result, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module least_laxity_job_scheduler_tb
  import llsched_pkg::*;
();

  localparam int NUM_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 2 * NUM_SLOTS + 10;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;

  least_laxity_job_scheduler #(.MAX_JOBS(NUM_SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the job table
  bit          job_valid [NUM_SLOTS];
  logic [7:0]  job_id    [NUM_SLOTS];
  logic [15:0] job_rel   [NUM_SLOTS];
  logic [15:0] job_left  [NUM_SLOTS];
  logic [15:0] job_dl    [NUM_SLOTS];
  logic [15:0] job_wait  [NUM_SLOTS];
  logic [15:0] job_cpu   [NUM_SLOTS];
  logic [15:0] job_order [NUM_SLOTS];
  logic [15:0] clock_now = '0;
  logic [15:0] insert_seq = '0;

  item_t   pending_jobs[$];
  bit      drain_first[$];
  result_t expected_results[$];

  int errors = 0;
  int n_adds = 0, n_ticks = 0, n_finished = 0, n_refused = 0, n_idle_ticks = 0;
  int n_sent = 0;
  int cycles = 0;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Apply one transfer to the local table and return the result it causes.
  function automatic result_t schedule_step(input item_t it);
    result_t r;
    int      best;
    int      lax;
    int      best_lax;
    r = '0;
    best = -1;
    best_lax = 0;
    if (it.operation == OP_ADD) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!job_valid[i] && best < 0) best = i;
      end
      if (best < 0) begin
        r.status = 1'b1;
      end else begin
        job_valid[best] = 1'b1;
        job_id[best]    = it.job_id;
        job_rel[best]   = it.release_time;
        job_left[best]  = it.exec_time;
        job_dl[best]    = it.abs_deadline;
        job_wait[best]  = '0;
        job_cpu[best]   = '0;
        job_order[best] = insert_seq;
        insert_seq      = insert_seq + 16'd1;
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (job_valid[i] && job_rel[i] <= clock_now) begin
          lax = int'(job_dl[i]) - int'(job_left[i]);
          if (best < 0 || lax < best_lax ||
              (lax == best_lax && job_order[i] < job_order[best])) begin
            best = i;
            best_lax = lax;
          end
        end
      end
      if (best >= 0) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (i != best && job_valid[i] && job_rel[i] <= clock_now)
            job_wait[i] = bump(job_wait[i]);
        end
        r.ran_valid = 1'b1;
        r.ran_id = job_id[best];
        job_cpu[best] = bump(job_cpu[best]);
        if (job_left[best] <= 16'd1) begin
          job_left[best]  = '0;
          r.done_res      = 1'b1;
          r.done_wait     = job_wait[best];
          r.done_cpu      = job_cpu[best];
          job_valid[best] = 1'b0;
        end else begin
          job_left[best] = job_left[best] - 16'd1;
        end
      end
      clock_now = clock_now + 16'd1;
    end
    r.now = clock_now;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Driver: hold start with the item until a transfer, then present the next
  // item or idle. Exactly one assignment to start per edge.
  always @(posedge clk) begin
    bit    next_start;
    item_t next_item;
    bit    accepted;
    next_start = start;
    next_item = item;
    accepted = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        // transfer: predict now, counting by kind
        result_t r;
        r = schedule_step(item);
        expected_results = {expected_results, r};
        if (item.operation == OP_ADD) begin
          n_adds++;
          if (r.status) n_refused++;
        end else begin
          n_ticks++;
          if (!r.ran_valid) n_idle_ticks++;
          if (r.done_res) n_finished++;
        end
        n_sent++;
        accepted = 1'b1;
        next_start = 1'b0;
      end
      if ((accepted || !start) && pending_jobs.size() > 0) begin
        // idle about a third of the time, but not in the quiet window
        if (!(drain_first[0] && (expected_results.size() > 0 || accepted)) &&
            ((n_sent >= 300 && n_sent < 450) || $urandom_range(99) >= 32)) begin
          next_item = pending_jobs.pop_front();
          void'(drain_first.pop_front());
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
    item <= next_item;
  end

  // Monitor: a result is valid for exactly one cycle
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result strobe with no result outstanding");
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("now",       32'(e.now),       32'(result.now));
        check_field("ran_valid", 32'(e.ran_valid), 32'(result.ran_valid));
        check_field("ran_id",    32'(e.ran_id),    32'(result.ran_id));
        check_field("done_res",  32'(e.done_res),  32'(result.done_res));
        check_field("done_wait", 32'(e.done_wait), 32'(result.done_wait));
        check_field("done_cpu",  32'(e.done_cpu),  32'(result.done_cpu));
        check_field("status",    32'(e.status),    32'(result.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic item_t make_add(input logic [7:0] id, input logic [15:0] rel,
                                     input logic [15:0] ex, input logic [15:0] dl);
    item_t it;
    it.operation = OP_ADD;
    it.job_id = id;
    it.release_time = rel;
    it.exec_time = ex;
    it.abs_deadline = dl;
    return it;
  endfunction

  function automatic item_t make_tick();
    item_t       it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = item_t'(raw[$bits(item_t)-1:0]);
    it.operation = OP_TICK;
    return it;
  endfunction

  function automatic void queue_item(input item_t it, input bit drain);
    pending_jobs = {pending_jobs, it};
    drain_first = {drain_first, drain};
  endfunction

  initial begin
    item_t       it;
    logic [15:0] gen_now;
    gen_now = '0;
    for (int i = 0; i < NUM_SLOTS; i++) job_valid[i] = 1'b0;

    // Directed: idle ticks, a zero-work job, a parked job that never releases,
    // a full table with laxity ties, a refused add, then a couple of ticks.
    queue_item(make_tick(), 1'b0);
    queue_item(make_tick(), 1'b0);
    queue_item(make_add(8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b0);
    queue_item(make_tick(), 1'b0);
    queue_item(make_add(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    for (int i = 0; i < NUM_SLOTS - 1; i++)
      queue_item(make_add(8'(i + 1), 16'd3, 16'd1, 16'd10 + 16'(i / 4)), 1'b0);
    queue_item(make_add(8'hAA, 16'h5555, 16'hAAAA, 16'h5555), 1'b0);
    queue_item(make_tick(), 1'b0);
    queue_item(make_tick(), 1'b0);
    gen_now = 16'd5;

    // Random: mostly plausible job streams near the current tick, some noise
    for (int n = 0; n < 850; n++) begin
      if ($urandom_range(99) < 55) begin
        it = make_tick();
        gen_now = gen_now + 16'd1;
      end else begin
        it = make_add(8'($urandom), gen_now + 16'($urandom_range(6)),
                      16'($urandom_range(1, 6)), '0);
        if ($urandom_range(19) == 0) it.exec_time = '0;
        it.abs_deadline = it.release_time + it.exec_time + 16'($urandom_range(20));
        if ($urandom_range(9) == 0) it.abs_deadline = 16'($urandom);
        if ($urandom_range(19) == 0) it.release_time = gen_now - 16'($urandom_range(4));
      end
      // let everything outstanding come back before these transfers
      queue_item(it, n == 0 || n == 400 || n == 700);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (pending_jobs.size() == 0 && !start && expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d adds (%0d refused on a full table) and %0d ticks",
             n_adds, n_refused, n_ticks);
    $display("  with %0d idle ticks and %0d jobs run to completion",
             n_idle_ticks, n_finished);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/llsched_pkg.sv
hw/rtl/llsched_ctrl.sv
hw/rtl/llsched_dp.sv
hw/rtl/least_laxity_job_scheduler.sv
tb/least_laxity_job_scheduler_tb.sv
